// ===== src/a2m_pkg.sv =====
package a2m_pkg;

    localparam int CHAR_W  = 8;
    localparam int PAT_W   = 6;
    localparam int LEN_W   = 3;
    localparam int SEQ_LEN = 8;
    localparam int IDX_W   = $clog2(SEQ_LEN);

    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_FOLD  = 8'h20;

    typedef enum logic [1:0] {
        SYM_DIT     = 2'd0,
        SYM_DAH     = 2'd1,
        SYM_SPACE   = 2'd2,
        SYM_NEWLINE = 2'd3
    } symbol_t;

    typedef struct packed {
        logic    last;
        symbol_t sym;
    } entry_t;

    // pat is left aligned, first element in the msb, 1 = dah
    typedef struct packed {
        logic             known;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
    } sign_t;

    function automatic sign_t a2m_lookup(input logic [CHAR_W-1:0] code, input logic itu_only);
        logic [CHAR_W-1:0] c;
        logic              non_itu;
        sign_t             s;
        c       = code;
        non_itu = 1'b0;
        if (code >= CHAR_LC_A && code <= CHAR_LC_Z)
        begin
            c = code - CASE_FOLD;
        end
        s.known = 1'b1;
        case (c)
            8'h41: begin s.len = 3'd2; s.pat = 6'b010000; end
            8'h42: begin s.len = 3'd4; s.pat = 6'b100000; end
            8'h43: begin s.len = 3'd4; s.pat = 6'b101000; end
            8'h44: begin s.len = 3'd3; s.pat = 6'b100000; end
            8'h45: begin s.len = 3'd1; s.pat = 6'b000000; end
            8'h46: begin s.len = 3'd4; s.pat = 6'b001000; end
            8'h47: begin s.len = 3'd3; s.pat = 6'b110000; end
            8'h48: begin s.len = 3'd4; s.pat = 6'b000000; end
            8'h49: begin s.len = 3'd2; s.pat = 6'b000000; end
            8'h4A: begin s.len = 3'd4; s.pat = 6'b011100; end
            8'h4B: begin s.len = 3'd3; s.pat = 6'b101000; end
            8'h4C: begin s.len = 3'd4; s.pat = 6'b010000; end
            8'h4D: begin s.len = 3'd2; s.pat = 6'b110000; end
            8'h4E: begin s.len = 3'd2; s.pat = 6'b100000; end
            8'h4F: begin s.len = 3'd3; s.pat = 6'b111000; end
            8'h50: begin s.len = 3'd4; s.pat = 6'b011000; end
            8'h51: begin s.len = 3'd4; s.pat = 6'b110100; end
            8'h52: begin s.len = 3'd3; s.pat = 6'b010000; end
            8'h53: begin s.len = 3'd3; s.pat = 6'b000000; end
            8'h54: begin s.len = 3'd1; s.pat = 6'b100000; end
            8'h55: begin s.len = 3'd3; s.pat = 6'b001000; end
            8'h56: begin s.len = 3'd4; s.pat = 6'b000100; end
            8'h57: begin s.len = 3'd3; s.pat = 6'b011000; end
            8'h58: begin s.len = 3'd4; s.pat = 6'b100100; end
            8'h59: begin s.len = 3'd4; s.pat = 6'b101100; end
            8'h5A: begin s.len = 3'd4; s.pat = 6'b110000; end
            8'h30: begin s.len = 3'd5; s.pat = 6'b111110; end
            8'h31: begin s.len = 3'd5; s.pat = 6'b011110; end
            8'h32: begin s.len = 3'd5; s.pat = 6'b001110; end
            8'h33: begin s.len = 3'd5; s.pat = 6'b000110; end
            8'h34: begin s.len = 3'd5; s.pat = 6'b000010; end
            8'h35: begin s.len = 3'd5; s.pat = 6'b000000; end
            8'h36: begin s.len = 3'd5; s.pat = 6'b100000; end
            8'h37: begin s.len = 3'd5; s.pat = 6'b110000; end
            8'h38: begin s.len = 3'd5; s.pat = 6'b111000; end
            8'h39: begin s.len = 3'd5; s.pat = 6'b111100; end
            8'h2E: begin s.len = 3'd6; s.pat = 6'b010101; end
            8'h2C: begin s.len = 3'd6; s.pat = 6'b110011; end
            8'h3A: begin s.len = 3'd6; s.pat = 6'b111000; end
            8'h3F: begin s.len = 3'd6; s.pat = 6'b001100; end
            8'h27: begin s.len = 3'd6; s.pat = 6'b011110; end
            8'h2D: begin s.len = 3'd6; s.pat = 6'b100001; end
            8'h2F: begin s.len = 3'd5; s.pat = 6'b100100; end
            8'h28: begin s.len = 3'd5; s.pat = 6'b101100; end
            8'h29: begin s.len = 3'd6; s.pat = 6'b101101; end
            8'h22: begin s.len = 3'd6; s.pat = 6'b010010; end
            8'h3D: begin s.len = 3'd5; s.pat = 6'b100010; end
            8'h2B: begin s.len = 3'd5; s.pat = 6'b010100; end
            8'h40: begin s.len = 3'd6; s.pat = 6'b011010; end
            8'h21: begin s.len = 3'd6; s.pat = 6'b101011; non_itu = 1'b1; end
            8'h3B: begin s.len = 3'd6; s.pat = 6'b101010; non_itu = 1'b1; end
            8'h5F: begin s.len = 3'd6; s.pat = 6'b001101; non_itu = 1'b1; end
            default:
            begin
                s.known = 1'b0;
                s.len   = '0;
                s.pat   = '0;
            end
        endcase
        if (itu_only && non_itu)
        begin
            s.known = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== src/a2m_ram.sv =====
module a2m_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ascii_to_morse_encoder_top.sv =====
// First symbol path: serialiser, symbol queue RAM, RAM read register, output register.
// Throughput: one symbol per cycle while the symbol queue is not full, set by the single write
// port of the symbol queue RAM; a character is at most 7 symbols long.
// Reset (rst_n, async, active low): itu_only cleared, word space flag cleared,
// queue empty; RAM contents are not reset.
module ascii_to_morse_encoder_top
    import a2m_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              itu_only,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] char_code,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        symbol,
    output logic              last
);

    localparam int AW = $clog2(FIFO_DEPTH);

    logic             itu_only_reg, itu_only_next;
    logic             wsd_reg, wsd_next;
    logic             busy_reg, busy_next;
    symbol_t          seq_reg [SEQ_LEN];
    symbol_t          seq_next [SEQ_LEN];
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [AW:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW:0]      rd_ptr_reg, rd_ptr_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             out_valid_reg, out_valid_next;
    entry_t           out_entry_reg, out_entry_next;
    logic             skid_valid_reg, skid_valid_next;
    entry_t           skid_entry_reg, skid_entry_next;

    sign_t            sign;
    logic             blank;
    logic             is_nl;
    logic [LEN_W-1:0] base_n;
    logic [LEN_W-1:0] new_n;
    symbol_t          new_seq [SEQ_LEN];
    logic             fifo_full, fifo_empty;
    logic             emit, emit_last;
    logic             in_fire;
    entry_t           wr_entry;
    entry_t           rd_entry;
    logic [1:0]       held;
    logic             pop;
    logic             rd_issue;

    // decode
    always_comb
    begin
        sign   = a2m_lookup(char_code, itu_only_reg);
        blank  = (char_code == CHAR_SPACE) || (char_code >= CHAR_TAB && char_code <= CHAR_CR);
        is_nl  = (char_code == CHAR_LF);
        if (sign.known && !blank)
        begin
            base_n = sign.len + 3'd1;
        end
        else if (wsd_reg)
        begin
            base_n = 3'd0;
        end
        else
        begin
            base_n = 3'd2;
        end
        new_n = base_n + {2'b00, is_nl};
        for (int i = 0; i < SEQ_LEN; i++)
        begin
            new_seq[i] = SYM_SPACE;
        end
        if (sign.known && !blank)
        begin
            for (int i = 0; i < PAT_W; i++)
            begin
                if (LEN_W'(i) < sign.len)
                begin
                    new_seq[i] = sign.pat[PAT_W-1-i] ? SYM_DAH : SYM_DIT;
                end
            end
        end
        for (int i = 0; i < SEQ_LEN; i++)
        begin
            if (is_nl && base_n == LEN_W'(i))
            begin
                new_seq[i] = SYM_NEWLINE;
            end
        end
    end

    // serialiser into the symbol queue
    assign fifo_full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                        (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign fifo_empty = (wr_ptr_reg == rd_ptr_reg);
    assign emit       = busy_reg && !fifo_full;
    assign emit_last  = emit && (idx_reg == cnt_reg - 3'd1);
    assign in_ready   = !busy_reg || emit_last;
    assign in_fire    = in_valid && in_ready;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        wr_entry.sym  = seq_reg[idx_reg];
        wr_entry.last = emit_last;
    end

    always_comb
    begin
        itu_only_next = itu_only_reg;
        wsd_next      = wsd_reg;
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        seq_next      = seq_reg;
        wr_ptr_next   = wr_ptr_reg;
        if (cfg_valid)
        begin
            itu_only_next = itu_only;
        end
        if (emit)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
            idx_next    = idx_reg + 1'b1;
        end
        if (emit_last)
        begin
            busy_next = 1'b0;
        end
        if (in_fire)
        begin
            wsd_next = !(sign.known && !blank);
            if (new_n != '0)
            begin
                busy_next = 1'b1;
                cnt_next  = new_n;
                idx_next  = '0;
                seq_next  = new_seq;
            end
        end
    end

    // queue read side with a two-deep output stage
    assign held     = {1'b0, out_valid_reg} + {1'b0, skid_valid_reg} + {1'b0, rd_pend_reg};
    assign pop      = out_valid_reg && out_ready;
    assign rd_issue = !fifo_empty && ((held - {1'b0, pop}) < 2'd2);

    a2m_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (emit),
        .waddr (wr_ptr_reg[AW-1:0]),
        .wdata (wr_entry),
        .re    (rd_issue),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (rd_entry)
    );

    always_comb
    begin
        rd_ptr_next     = rd_issue ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        rd_pend_next    = rd_issue;
        out_valid_next  = out_valid_reg;
        out_entry_next  = out_entry_reg;
        skid_valid_next = skid_valid_reg;
        skid_entry_next = skid_entry_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_entry_next  = skid_entry_reg;
                skid_valid_next = rd_pend_reg;
                skid_entry_next = rd_entry;
            end
            else if (rd_pend_reg)
            begin
                out_valid_next = 1'b1;
                out_entry_next = rd_entry;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (rd_pend_reg)
        begin
            skid_valid_next = 1'b1;
            skid_entry_next = rd_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itu_only_reg   <= 1'b0;
            wsd_reg        <= 1'b0;
            busy_reg       <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            itu_only_reg   <= itu_only_next;
            wsd_reg        <= wsd_next;
            busy_reg       <= busy_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        seq_reg        <= seq_next;
        out_entry_reg  <= out_entry_next;
        skid_entry_reg <= skid_entry_next;
    end

    assign out_valid = out_valid_reg;
    assign symbol    = out_entry_reg.sym;
    assign last      = out_entry_reg.last;

endmodule

// ===== dv/tb_ascii_to_morse_encoder_top.sv =====
module tb_ascii_to_morse_encoder_top
    import a2m_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_CYCLES = 16;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_PCT = 13;
    localparam int HOLD_AT_SYMBOL = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int RX_CALM_LO = 700;
    localparam int RX_CALM_HI = 1100;
    localparam int PHASE_ITEMS = 135;

    typedef enum logic [1:0] {
        TX_CHAR,
        TX_CFG,
        TX_DRAIN
    } tx_kind_t;

    typedef struct {
        tx_kind_t          kind;
        logic [CHAR_W-1:0] data;
        logic              calm;
    } pend_item_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              itu_only;
    logic              in_valid;
    logic              in_ready;
    logic [CHAR_W-1:0] char_code;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        symbol;
    logic              last;

    pend_item_t pend_q[$];
    entry_t     pending_symbols[$];

    int in_sent   = 0;
    int in_acc    = 0;
    int cfg_sent  = 0;
    int cfg_acc   = 0;
    int sym_acc   = 0;
    int quiet_cnt = 0;
    int hold_left = 0;
    int fail_cnt  = 0;
    int cycle_cnt = 0;
    bit hold_done = 1'b0;

    // encoder state as seen from outside
    logic strict_itu = 1'b0;
    logic gap_sent   = 1'b0;

    ascii_to_morse_encoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .itu_only  (itu_only),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .last      (last)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic string morse_of(input logic [CHAR_W-1:0] code, input logic strict);
        logic [CHAR_W-1:0] u;
        string             p;
        u = code;
        p = "";
        if (code >= CHAR_LC_A && code <= CHAR_LC_Z)
        begin
            u = code - CASE_FOLD;
        end
        case (u)
            "A": p = ".-";
            "B": p = "-...";
            "C": p = "-.-.";
            "D": p = "-..";
            "E": p = ".";
            "F": p = "..-.";
            "G": p = "--.";
            "H": p = "....";
            "I": p = "..";
            "J": p = ".---";
            "K": p = "-.-";
            "L": p = ".-..";
            "M": p = "--";
            "N": p = "-.";
            "O": p = "---";
            "P": p = ".--.";
            "Q": p = "--.-";
            "R": p = ".-.";
            "S": p = "...";
            "T": p = "-";
            "U": p = "..-";
            "V": p = "...-";
            "W": p = ".--";
            "X": p = "-..-";
            "Y": p = "-.--";
            "Z": p = "--..";
            "0": p = "-----";
            "1": p = ".----";
            "2": p = "..---";
            "3": p = "...--";
            "4": p = "....-";
            "5": p = ".....";
            "6": p = "-....";
            "7": p = "--...";
            "8": p = "---..";
            "9": p = "----.";
            ".": p = ".-.-.-";
            ",": p = "--..--";
            ":": p = "---...";
            "?": p = "..--..";
            "'": p = ".----.";
            "-": p = "-....-";
            "/": p = "-..-.";
            "(": p = "-.--.";
            ")": p = "-.--.-";
            "\"": p = ".-..-.";
            "=": p = "-...-";
            "+": p = ".-.-.";
            "@": p = ".--.-.";
            "!":
            begin
                if (!strict)
                begin
                    p = "-.-.--";
                end
            end
            ";":
            begin
                if (!strict)
                begin
                    p = "-.-.-.";
                end
            end
            "_":
            begin
                if (!strict)
                begin
                    p = "..--.-";
                end
            end
            default: p = "";
        endcase
        return p;
    endfunction

    function automatic void push_sym(input symbol_t s);
        entry_t e;
        e.sym  = s;
        e.last = 1'b0;
        pending_symbols.push_back(e);
    endfunction

    function automatic void encode_char(input logic [CHAR_W-1:0] code);
        string p;
        logic  blank;
        int    first;
        int    k;
        blank = (code == CHAR_SPACE) || (code >= CHAR_TAB && code <= CHAR_CR);
        p     = morse_of(code, strict_itu);
        first = pending_symbols.size();
        if (blank || p.len() == 0)
        begin
            if (!gap_sent)
            begin
                push_sym(SYM_SPACE);
                push_sym(SYM_SPACE);
                gap_sent = 1'b1;
            end
        end
        else
        begin
            gap_sent = 1'b0;
            for (k = 0; k < p.len(); k++)
            begin
                push_sym((p[k] == ".") ? SYM_DIT : SYM_DAH);
            end
            push_sym(SYM_SPACE);
        end
        if (code == CHAR_LF)
        begin
            push_sym(SYM_NEWLINE);
        end
        if (pending_symbols.size() > first)
        begin
            pending_symbols[pending_symbols.size()-1].last = 1'b1;
        end
    endfunction

    function automatic void note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
        begin
            $display("%s", msg);
        end
    endfunction

    function automatic logic [CHAR_W-1:0] random_char();
        string marks = ".,:?'-/()\"=+@!;_";
        int    pick;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            if ($urandom_range(1) == 0)
            begin
                return CHAR_W'("A" + $urandom_range(25));
            end
            return CHAR_W'(CHAR_LC_A + $urandom_range(25));
        end
        if (pick < 52)
        begin
            return CHAR_W'("0" + $urandom_range(9));
        end
        if (pick < 66)
        begin
            return marks[$urandom_range(marks.len() - 1)];
        end
        if (pick < 88)
        begin
            if ($urandom_range(2) == 0)
            begin
                return CHAR_SPACE;
            end
            return CHAR_W'(CHAR_TAB + $urandom_range(4));
        end
        return CHAR_W'($urandom_range(255));
    endfunction

    function automatic void queue_char(input logic [CHAR_W-1:0] c, input logic calm);
        pend_item_t it;
        it.kind = TX_CHAR;
        it.data = c;
        it.calm = calm;
        pend_q.push_back(it);
    endfunction

    function automatic void queue_op(input tx_kind_t kind, input logic value);
        pend_item_t it;
        it.kind = kind;
        it.data = CHAR_W'(value);
        it.calm = 1'b0;
        pend_q.push_back(it);
    endfunction

    // monitor: prediction on input transactions, check on output transactions
    always @(posedge clk)
    begin : monitor
        entry_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                strict_itu = itu_only;
                cfg_acc++;
            end
            if (in_valid && in_ready)
            begin
                encode_char(char_code);
                in_acc++;
            end
            if (out_valid && out_ready)
            begin
                sym_acc++;
                if (pending_symbols.size() == 0)
                begin
                    note_fail($sformatf("unexpected symbol %0d last %0d", symbol, last));
                end
                else
                begin
                    want = pending_symbols.pop_front();
                    if (want.sym !== symbol)
                    begin
                        note_fail($sformatf("symbol %0d: expected %0d, got %0d",
                                            sym_acc, want.sym, symbol));
                    end
                    if (want.last !== last)
                    begin
                        note_fail($sformatf("last at symbol %0d: expected %0d, got %0d",
                                            sym_acc, want.last, last));
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin : driver
        pend_item_t it;
        logic       nv;
        logic       ncv;
        if (rst_n)
        begin
            nv  = in_valid && (in_acc != in_sent);
            ncv = cfg_valid && (cfg_acc != cfg_sent);
            if (pending_symbols.size() == 0 && in_acc == in_sent && cfg_acc == cfg_sent)
            begin
                quiet_cnt++;
            end
            else
            begin
                quiet_cnt = 0;
            end
            if (!nv && !ncv && pend_q.size() > 0)
            begin
                it = pend_q[0];
                case (it.kind)
                    TX_CHAR:
                    begin
                        if (it.calm || $urandom_range(99) >= IDLE_PCT)
                        begin
                            nv = 1'b1;
                            char_code <= it.data;
                            in_sent++;
                            void'(pend_q.pop_front());
                        end
                    end
                    TX_CFG:
                    begin
                        if (quiet_cnt >= QUIET_CYCLES)
                        begin
                            ncv = 1'b1;
                            itu_only <= it.data[0];
                            cfg_sent++;
                            quiet_cnt = 0;
                            void'(pend_q.pop_front());
                        end
                    end
                    default:
                    begin
                        if (quiet_cnt >= QUIET_CYCLES)
                        begin
                            void'(pend_q.pop_front());
                        end
                    end
                endcase
            end
            in_valid  <= nv;
            cfg_valid <= ncv;
        end
    end

    always @(negedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && sym_acc >= HOLD_AT_SYMBOL)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (sym_acc >= RX_CALM_LO && sym_acc < RX_CALM_HI)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int   ph;
        int   n;
        logic setting;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        itu_only  = 1'b0;
        in_valid  = 1'b0;
        char_code = '0;
        out_ready = 1'b0;

        queue_op(TX_CFG, 1'b0);
        queue_char("A", 1'b0);
        queue_char("z", 1'b0);
        queue_char("e", 1'b0);
        queue_char("0", 1'b0);
        queue_char("9", 1'b0);
        queue_char(".", 1'b0);
        queue_char("=", 1'b0);
        queue_char("!", 1'b0);
        queue_char(";", 1'b0);
        queue_char("_", 1'b0);
        queue_char(CHAR_SPACE, 1'b0);
        queue_char(CHAR_SPACE, 1'b0);
        queue_char(CHAR_LF, 1'b0);
        queue_char("H", 1'b0);
        queue_char(CHAR_LF, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(8'h80, 1'b0);
        queue_char("@", 1'b0);
        queue_char(CHAR_CR, 1'b0);
        queue_op(TX_CFG, 1'b1);
        queue_char("!", 1'b0);
        queue_char(";", 1'b0);
        queue_char("_", 1'b0);
        queue_char("k", 1'b0);

        for (ph = 0; ph < 3; ph++)
        begin
            setting = (ph != 1);
            queue_op(TX_CFG, setting);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 1 && n == 70)
                begin
                    queue_op(TX_DRAIN, 1'b0);
                end
                queue_char(random_char(), ph == 1 && n >= 20 && n < 120);
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || in_acc != in_sent || cfg_acc != cfg_sent
               || pending_symbols.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET_CYCLES) @(posedge clk);

        if (pending_symbols.size() != 0)
        begin
            note_fail($sformatf("%0d symbols never arrived", pending_symbols.size()));
        end
        if (fail_cnt == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/a2m_pkg.sv
src/a2m_ram.sv
src/ascii_to_morse_encoder_top.sv
dv/tb_ascii_to_morse_encoder_top.sv
